@@ rtl/core/chs_pkg.sv @@
// Shared types, constants and helpers for the convex hull block.
`timescale 1ns / 1ps

package chs_pkg;

    // Default store capacity in points
    localparam int MAX_POINTS_DEF = 16;
    // Fewest kept points that form a hull
    localparam int MIN_HULL = 3;
    // Width of a coordinate difference and of a product of two of them
    localparam int DIFF_W = 17;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ACC_W  = PROD_W + 2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
    } pt_t;

    // Exact difference of two coordinates
    function automatic logic signed [DIFF_W-1:0] diff17(input logic signed [15:0] a,
                                                       input logic signed [15:0] b);
        logic signed [DIFF_W-1:0] r;
        r = {a[15], a} - {b[15], b};
        return r;
    endfunction

endpackage

@@ rtl/core/chs_mul.sv @@
// Shared signed multiplier with a registered product.
`timescale 1ns / 1ps

module chs_mul
    import chs_pkg::*;
(
    input  logic                     clk,
    input  logic signed [DIFF_W-1:0] mul_a,
    input  logic signed [DIFF_W-1:0] mul_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    // Register every product for use in the following cycle
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    assign prod = prod_reg;

endmodule

@@ rtl/core/convex_hull_graham_scan_top.sv @@
// Graham scan convex hull: point store, pivot search, sort, prune, scan, vertex output.
// Loading: one point a cycle while busy is low; a point without the last mark gives no result.
// After the last point busy rises: pivot search, insertion sort (each compare runs through the
// one shared multiplier), prune and scan, then the vertex beats, which the receiver cannot stall.
// Busy falls as the final beat goes out. rst_n clears control state at once; memories are not.
`timescale 1ns / 1ps

module convex_hull_graham_scan_top
    import chs_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] point_x,
    input  logic signed [15:0] point_y,
    input  logic               last_point,
    output logic               strobe,
    output logic signed [15:0] vertex_x,
    output logic signed [15:0] vertex_y,
    output logic               hull_valid,
    output logic               overflow,
    output logic               last_vertex
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);
    localparam logic [CW-1:0] CNT_HULL = CW'(MIN_HULL);

    typedef enum logic [5:0] {
        ST_IDLE, ST_PV_RD, ST_PV_CMP, ST_SW_RD, ST_SW_W0, ST_SW_W1,
        ST_SO_I, ST_SO_T, ST_SO_J, ST_SO_R, ST_SO_D,
        ST_PR_A, ST_PR_Q, ST_PR_N, ST_PR_R, ST_PR_C, ST_PR_W,
        ST_SC_0, ST_SC_1, ST_SC_2, ST_SC_3, ST_SC_I, ST_SC_T, ST_SC_L, ST_SC_D, ST_SC_P,
        ST_EM_RD, ST_EM_OUT, ST_EM_BAD,
        ST_C0, ST_C1, ST_C2, ST_C3, ST_C4, ST_C5, ST_C6
    } state_t;

    state_t state_reg, ret_reg;

    logic [CW-1:0] count_reg, i_reg, j_reg, m_reg, depth_reg, e_reg;
    logic [AW-1:0] mi_reg;
    logic          ovf_reg, busy_reg, prec_reg, neg_reg;
    pt_t           piv_reg, t_reg, cand_reg, top1_reg, top2_reg;
    pt_t           op_p_reg, op_q_reg, op_r_reg;
    logic signed [ACC_W-1:0] acc_reg, acc2_reg;

    logic          strobe_reg, valid_reg, ovfo_reg, lastv_reg;
    pt_t           vtx_reg;

    // Memories
    pt_t           w_mem [MAX_POINTS];
    pt_t           s_mem [MAX_POINTS];
    pt_t           w_rd, s_rd;
    logic          w_we, s_we;
    logic [AW-1:0] w_wa, w_ra, s_wa, s_ra;
    pt_t           w_wd, s_wd;

    logic signed [DIFF_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    logic signed [ACC_W-1:0]  prod_ext, v_diff;

    chs_mul u_mul (
        .clk   (clk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
    assign v_diff   = acc_reg - prod_ext;

    // Point store
    always_ff @(posedge clk)
    begin
        if (w_we)
        begin
            w_mem[w_wa] <= w_wd;
        end
        w_rd <= w_mem[w_ra];
    end

    // Hull stack
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            s_mem[s_wa] <= s_wd;
        end
        s_rd <= s_mem[s_ra];
    end

    // Drive memory ports and multiplier operands from the sequencer
    always_comb
    begin
        w_we  = 1'b0;
        w_wa  = '0;
        w_wd  = piv_reg;
        w_ra  = '0;
        s_we  = 1'b0;
        s_wa  = '0;
        s_wd  = cand_reg;
        s_ra  = '0;
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && (count_reg < CNT_MAX))
                begin
                    w_we = 1'b1;
                    w_wa = count_reg[AW-1:0];
                    w_wd = '{x: point_x, y: point_y};
                end
            end
            ST_PV_RD: w_ra = i_reg[AW-1:0];
            ST_SW_W0:
            begin
                w_we = 1'b1;
                w_wa = mi_reg;
                w_wd = w_rd;
            end
            ST_SW_W1: w_we = 1'b1;
            ST_SO_I:  w_ra = i_reg[AW-1:0];
            ST_SO_J:
            begin
                if (j_reg > CW'(1))
                begin
                    w_ra = AW'(j_reg - 1'b1);
                end
                else
                begin
                    w_we = 1'b1;
                    w_wa = j_reg[AW-1:0];
                    w_wd = t_reg;
                end
            end
            ST_SO_D:
            begin
                w_we = 1'b1;
                w_wa = j_reg[AW-1:0];
                w_wd = neg_reg ? op_r_reg : t_reg;
            end
            ST_PR_A:  w_ra = i_reg[AW-1:0];
            ST_PR_N:  w_ra = AW'(i_reg + 1'b1);
            ST_PR_W:
            begin
                w_we = 1'b1;
                w_wa = m_reg[AW-1:0];
                w_wd = cand_reg;
            end
            ST_SC_0:  w_ra = AW'(1);
            ST_SC_1:
            begin
                w_ra = AW'(2);
                s_we = 1'b1;
                s_wa = AW'(1);
                s_wd = w_rd;
            end
            ST_SC_2:
            begin
                s_we = 1'b1;
                s_wa = AW'(2);
                s_wd = w_rd;
            end
            ST_SC_3:
            begin
                s_we = 1'b1;
                s_wd = piv_reg;
            end
            ST_SC_I:  w_ra = i_reg[AW-1:0];
            ST_SC_L:
            begin
                if ((depth_reg <= CW'(2)) && (depth_reg < CNT_MAX))
                begin
                    s_we = 1'b1;
                    s_wa = depth_reg[AW-1:0];
                end
            end
            ST_SC_D:
            begin
                if (neg_reg)
                begin
                    s_we = (depth_reg < CNT_MAX);
                    s_wa = depth_reg[AW-1:0];
                end
                else
                begin
                    s_ra = AW'(depth_reg - CW'(3));
                end
            end
            ST_EM_RD: s_ra = e_reg[AW-1:0];
            ST_C0:
            begin
                mul_a = diff17(op_q_reg.y, op_p_reg.y);
                mul_b = diff17(op_r_reg.x, op_q_reg.x);
            end
            ST_C1:
            begin
                mul_a = diff17(op_q_reg.x, op_p_reg.x);
                mul_b = diff17(op_r_reg.y, op_q_reg.y);
            end
            ST_C2:
            begin
                mul_a = diff17(op_q_reg.x, op_p_reg.x);
                mul_b = mul_a;
            end
            ST_C3:
            begin
                mul_a = diff17(op_q_reg.y, op_p_reg.y);
                mul_b = mul_a;
            end
            ST_C4:
            begin
                mul_a = diff17(op_r_reg.x, op_p_reg.x);
                mul_b = mul_a;
            end
            ST_C5:
            begin
                mul_a = diff17(op_r_reg.y, op_p_reg.y);
                mul_b = mul_a;
            end
            default: ;
        endcase
    end

    // Sequencer: state, counters, working registers and result beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ret_reg    <= ST_IDLE;
            count_reg  <= '0;
            i_reg      <= '0;
            j_reg      <= '0;
            m_reg      <= '0;
            depth_reg  <= '0;
            e_reg      <= '0;
            mi_reg     <= '0;
            ovf_reg    <= 1'b0;
            busy_reg   <= 1'b0;
            prec_reg   <= 1'b0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        if (count_reg < CNT_MAX)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_reg <= 1'b1;
                        end
                        if (last_point)
                        begin
                            busy_reg  <= 1'b1;
                            i_reg     <= '0;
                            state_reg <= ST_PV_RD;
                        end
                    end
                end
                // Find the pivot: lowest y, then lowest x
                ST_PV_RD: state_reg <= ST_PV_CMP;
                ST_PV_CMP:
                begin
                    if ((i_reg == '0) || (w_rd.y < piv_reg.y) ||
                        ((w_rd.y == piv_reg.y) && (w_rd.x < piv_reg.x)))
                    begin
                        piv_reg <= w_rd;
                        mi_reg  <= i_reg[AW-1:0];
                    end
                    if (i_reg == count_reg - 1'b1)
                    begin
                        state_reg <= ST_SW_RD;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_PV_RD;
                    end
                end
                // Swap the pivot into slot zero
                ST_SW_RD: state_reg <= ST_SW_W0;
                ST_SW_W0: state_reg <= ST_SW_W1;
                ST_SW_W1:
                begin
                    i_reg     <= CW'(2);
                    state_reg <= ST_SO_I;
                end
                // Insertion sort by angle about the pivot
                ST_SO_I:
                begin
                    if (i_reg >= count_reg)
                    begin
                        i_reg     <= CW'(1);
                        m_reg     <= CW'(1);
                        state_reg <= ST_PR_A;
                    end
                    else
                    begin
                        state_reg <= ST_SO_T;
                    end
                end
                ST_SO_T:
                begin
                    t_reg     <= w_rd;
                    j_reg     <= i_reg;
                    state_reg <= ST_SO_J;
                end
                ST_SO_J:
                begin
                    if (j_reg > CW'(1))
                    begin
                        state_reg <= ST_SO_R;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SO_I;
                    end
                end
                ST_SO_R:
                begin
                    op_p_reg  <= piv_reg;
                    op_q_reg  <= t_reg;
                    op_r_reg  <= w_rd;
                    prec_reg  <= 1'b1;
                    ret_reg   <= ST_SO_D;
                    state_reg <= ST_C0;
                end
                ST_SO_D:
                begin
                    if (neg_reg)
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= ST_SO_J;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SO_I;
                    end
                end
                // Keep only the farthest of each run collinear with the pivot
                ST_PR_A:
                begin
                    if (i_reg >= count_reg)
                    begin
                        state_reg <= (m_reg < CNT_HULL) ? ST_EM_BAD : ST_SC_0;
                    end
                    else
                    begin
                        state_reg <= ST_PR_Q;
                    end
                end
                ST_PR_Q:
                begin
                    cand_reg  <= w_rd;
                    state_reg <= ST_PR_N;
                end
                ST_PR_N:
                begin
                    state_reg <= ((i_reg + 1'b1) < count_reg) ? ST_PR_R : ST_PR_W;
                end
                ST_PR_R:
                begin
                    op_p_reg  <= piv_reg;
                    op_q_reg  <= cand_reg;
                    op_r_reg  <= w_rd;
                    prec_reg  <= 1'b0;
                    ret_reg   <= ST_PR_C;
                    state_reg <= ST_C0;
                end
                ST_PR_C:
                begin
                    if (acc_reg == '0)
                    begin
                        cand_reg  <= op_r_reg;
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_PR_N;
                    end
                    else
                    begin
                        state_reg <= ST_PR_W;
                    end
                end
                ST_PR_W:
                begin
                    m_reg     <= m_reg + 1'b1;
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_PR_A;
                end
                // Seed the stack with the first three kept points
                ST_SC_0: state_reg <= ST_SC_1;
                ST_SC_1:
                begin
                    top2_reg  <= w_rd;
                    state_reg <= ST_SC_2;
                end
                ST_SC_2:
                begin
                    top1_reg  <= w_rd;
                    state_reg <= ST_SC_3;
                end
                ST_SC_3:
                begin
                    depth_reg <= CW'(3);
                    i_reg     <= CW'(3);
                    state_reg <= ST_SC_I;
                end
                // Scan: pop while the turn is not counterclockwise, then push
                ST_SC_I:
                begin
                    if (i_reg >= m_reg)
                    begin
                        e_reg     <= '0;
                        state_reg <= ST_EM_RD;
                    end
                    else
                    begin
                        state_reg <= ST_SC_T;
                    end
                end
                ST_SC_T:
                begin
                    cand_reg  <= w_rd;
                    state_reg <= ST_SC_L;
                end
                ST_SC_L:
                begin
                    if (depth_reg > CW'(2))
                    begin
                        op_p_reg  <= top2_reg;
                        op_q_reg  <= top1_reg;
                        op_r_reg  <= cand_reg;
                        prec_reg  <= 1'b0;
                        ret_reg   <= ST_SC_D;
                        state_reg <= ST_C0;
                    end
                    else
                    begin
                        if (depth_reg < CNT_MAX)
                        begin
                            top2_reg  <= top1_reg;
                            top1_reg  <= cand_reg;
                            depth_reg <= depth_reg + 1'b1;
                        end
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SC_I;
                    end
                end
                ST_SC_D:
                begin
                    if (neg_reg)
                    begin
                        if (depth_reg < CNT_MAX)
                        begin
                            top2_reg  <= top1_reg;
                            top1_reg  <= cand_reg;
                            depth_reg <= depth_reg + 1'b1;
                        end
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= ST_SC_I;
                    end
                    else
                    begin
                        depth_reg <= depth_reg - 1'b1;
                        top1_reg  <= top2_reg;
                        state_reg <= ST_SC_P;
                    end
                end
                ST_SC_P:
                begin
                    top2_reg  <= s_rd;
                    state_reg <= ST_SC_L;
                end
                // Emit the stack, one beat per vertex, or one invalid beat if too few points are kept
                ST_EM_RD: state_reg <= ST_EM_OUT;
                ST_EM_OUT:
                begin
                    strobe_reg <= 1'b1;
                    vtx_reg    <= s_rd;
                    valid_reg  <= 1'b1;
                    ovfo_reg   <= ovf_reg;
                    lastv_reg  <= (e_reg == depth_reg - 1'b1);
                    e_reg      <= e_reg + 1'b1;
                    if (e_reg == depth_reg - 1'b1)
                    begin
                        count_reg <= '0;
                        ovf_reg   <= 1'b0;
                        busy_reg  <= 1'b0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        state_reg <= ST_EM_RD;
                    end
                end
                ST_EM_BAD:
                begin
                    strobe_reg <= 1'b1;
                    vtx_reg    <= '0;
                    valid_reg  <= 1'b0;
                    ovfo_reg   <= ovf_reg;
                    lastv_reg  <= 1'b1;
                    count_reg  <= '0;
                    ovf_reg    <= 1'b0;
                    busy_reg   <= 1'b0;
                    state_reg  <= ST_IDLE;
                end
                // Orientation, then squared distances for a collinear sort key
                ST_C0: state_reg <= ST_C1;
                ST_C1:
                begin
                    acc_reg   <= prod_ext;
                    state_reg <= ST_C2;
                end
                ST_C2:
                begin
                    acc_reg <= v_diff;
                    neg_reg <= v_diff[ACC_W-1];
                    if (!prec_reg || (v_diff != '0))
                    begin
                        state_reg <= ret_reg;
                    end
                    else
                    begin
                        state_reg <= ST_C3;
                    end
                end
                ST_C3:
                begin
                    acc_reg   <= prod_ext;
                    state_reg <= ST_C4;
                end
                ST_C4:
                begin
                    acc_reg   <= acc_reg + prod_ext;
                    state_reg <= ST_C5;
                end
                ST_C5:
                begin
                    acc2_reg  <= prod_ext;
                    state_reg <= ST_C6;
                end
                ST_C6:
                begin
                    neg_reg   <= (acc_reg < (acc2_reg + prod_ext));
                    state_reg <= ret_reg;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign busy        = busy_reg;
    assign strobe      = strobe_reg;
    assign vertex_x    = vtx_reg.x;
    assign vertex_y    = vtx_reg.y;
    assign hull_valid  = valid_reg;
    assign overflow    = ovfo_reg;
    assign last_vertex = lastv_reg;

    // Nothing follows the final beat of a hull
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last_vertex |=> !strobe)
        else $error("beat after final vertex");

    // An invalid result is always the only one
    a_bad_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !hull_valid |-> last_vertex)
        else $error("invalid result not marked final");

    // Stack never grows past capacity
    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= CNT_MAX)
        else $error("hull stack overrun");

    // A beat goes out only while the hull is being delivered
    a_beat_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy_reg))
        else $error("beat outside computation");

endmodule
